/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`endif

/* hw/rtl/grc_pkg.sv */
// Types and constants of the grid ray caster
package grc_pkg;
  localparam int MAX_COLS = 32;
  localparam int MAX_ROWS = 32;
  localparam int POS_W    = 17;
  localparam int FRAC     = 12;
  localparam int DIR_W    = 16;
  localparam int DIR_FRAC = 14;
  localparam int ADIR_W   = 16;
  localparam int CELL_W   = 7;
  localparam int LINE_W   = 20;
  localparam int MAG_W    = 19;
  localparam int PROD_W   = MAG_W + ADIR_W;
  localparam int HP_W     = 21;
  localparam int DIFF_W   = 22;
  localparam int MUL_W    = DIFF_W + DIR_W;
  localparam int DOT_W    = MUL_W + 1;
  localparam int NUM_W    = 10 + FRAC + DIR_FRAC;
  localparam int DEN_W    = DOT_W - 1;
  localparam int QUO_W    = 20;
  localparam int HT_W     = 10;
  localparam int COLOR_W  = 8;
  localparam int DIM_W    = 6;
  localparam int SH_W     = 10;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [HT_W-1:0] HEIGHT_MAX = 10'd1023;
  localparam logic [DIM_W-1:0] WIDTH_RST = 6'd30;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 6'd20;
  localparam logic [SH_W-1:0] SCREEN_RST = 10'd200;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCREEN_H   = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [4:0]               tile_col;
    logic [4:0]               tile_row;
    logic [COLOR_W-1:0]       tile_value;
    logic [POS_W-1:0]         start_x;
    logic [POS_W-1:0]         start_y;
    logic signed [DIR_W-1:0]  dir_x;
    logic signed [DIR_W-1:0]  dir_y;
    logic signed [DIR_W-1:0]  fwd_x;
    logic signed [DIR_W-1:0]  fwd_y;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [POS_W-1:0]   hit_x;
    logic [POS_W-1:0]   hit_y;
    logic [COLOR_W-1:0] hit_color;
    logic [HT_W-1:0]    col_height;
  } rsp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;
endpackage

/* hw/rtl/grc_ram.sv */
// Generic simple dual-port RAM with registered read
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/grc_div.sv */
// Restoring divider, one quotient bit per cycle
module grc_div (
  input  logic               clk,
  input  logic               rst,
  input  grc_pkg::div_req_t  req,
  output grc_pkg::div_rsp_t  rsp
);
  localparam int QW  = grc_pkg::QUO_W;
  localparam int DSW = grc_pkg::DEN_W + QW;
  localparam int CW  = $clog2(QW);

  logic [grc_pkg::NUM_W-1:0] rem;
  logic [DSW-1:0]            ds;
  logic [QW-1:0]             quo;
  logic [CW-1:0]             cnt;
  logic                      busy;
  logic                      ovf;
  logic                      done;
  logic                      ge;

  assign ge = DSW'(rem) >= ds;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      ds  <= {1'b0, req.den, {(QW-1){1'b0}}};
      quo <= '0;
      ovf <= DSW'(req.num) >= {req.den, {QW{1'b0}}};
    end else if (busy) begin
      if (ge) begin
        rem <= rem - ds[grc_pkg::NUM_W-1:0];
      end
      quo <= {quo[QW-2:0], ge};
      ds  <= ds >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.ovf  = ovf;
  assign rsp.quo  = quo;
endmodule

/* hw/rtl/grid_ray_caster_unit.sv */
// Grid ray caster top level: tile map, ray walk sequencer, APB registers
// After reset the tile map is cleared one entry a cycle, all MAX_COLS*MAX_ROWS
// entries (1024 by default), before the first item is taken. A tile write, like
// a cast that starts outside the map, goes from idle straight to the done state.
// A cast reads one tile per grid cell visited; each cell passes a registered RAM
// read state, then the crossing decision. A hit after a crossing uses the shared
// divider twice (hit point, then wall height when the dot product is positive),
// with the multiply and sum states between. A hit in the start tile skips the
// hit point division. The result sits in an output register, and the next item
// is taken while it waits.
module grid_ray_caster_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  grc_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output grc_pkg::rsp_t                rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [grc_pkg::PADDR_W-1:0]  paddr,
  input  logic [grc_pkg::PDATA_W-1:0]  pwdata,
  output logic [grc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  `include "assert_macros.svh"

  localparam int MAX_COLS = grc_pkg::MAX_COLS;
  localparam int MAX_ROWS = grc_pkg::MAX_ROWS;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = grc_pkg::CELL_W;
  localparam int LW    = grc_pkg::LINE_W;
  localparam int ONE   = 1 << grc_pkg::FRAC;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_CHK   = 9'b000001000,
    S_OFF   = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_SUM   = 9'b001000000,
    S_HT    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  logic [grc_pkg::DIM_W-1:0] map_width;
  logic [grc_pkg::DIM_W-1:0] map_height;
  logic [grc_pkg::SH_W-1:0]  view_height;

  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic [grc_pkg::COLOR_W-1:0]       ram_wdata;
  logic [AW-1:0]                     ram_raddr;
  logic [grc_pkg::COLOR_W-1:0]       ram_rdata;
  logic [AW-1:0]                     clr_addr;

  grc_pkg::div_req_t div_req;
  grc_pkg::div_rsp_t div_rsp;
  logic              div_run;

  logic [grc_pkg::POS_W-1:0]          sx, sy;
  logic signed [grc_pkg::DIR_W-1:0]   dx, dy, fx, fy;
  logic [grc_pkg::ADIR_W-1:0]         adx, ady;
  logic [CW-1:0]                      w, h;
  logic signed [CW-1:0]               cx, cy;
  logic signed [LW-1:0]               nxl, nyl;
  logic [grc_pkg::PROD_W-1:0]         pdx, pdy;
  logic                               last_x;
  logic signed [LW-1:0]               last_line;
  logic [grc_pkg::PROD_W-1:0]         last_p;
  logic [grc_pkg::ADIR_W-1:0]         last_a;
  logic                               crossed;
  logic [grc_pkg::COLOR_W-1:0]        color;
  logic signed [grc_pkg::HP_W-1:0]    hx, hy;
  logic signed [grc_pkg::MUL_W-1:0]   m1, m2;
  logic signed [grc_pkg::DOT_W-1:0]   dot;
  logic                               res_hit;
  logic [grc_pkg::HT_W-1:0]           res_ht;

  logic                               accept;
  logic                               wr_in_range;
  logic [AW-1:0]                      wr_idx;
  logic [CW-1:0]                      w_in, h_in;
  logic [CW-1:0]                      cx_in, cy_in;
  logic signed [LW:0]                 ddx, ddy;
  logic [grc_pkg::MAG_W-1:0]          distx, disty;
  logic                               dx_pos, dy_pos, takex;
  logic signed [CW-1:0]               cx_step, cy_step;
  logic signed [grc_pkg::HP_W-1:0]    off_s, sx_s, sy_s;
  logic signed [grc_pkg::DIFF_W-1:0]  diffx, diffy;
  logic signed [grc_pkg::DIR_W-1:0]   adx_full, ady_full;
  logic                               rsp_data_zero;

  assign pready    = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // APB registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width   <= grc_pkg::WIDTH_RST;
      map_height  <= grc_pkg::HEIGHT_RST;
      view_height <= grc_pkg::SCREEN_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        grc_pkg::REG_MAP_WIDTH:  map_width   <= pwdata[grc_pkg::DIM_W-1:0];
        grc_pkg::REG_MAP_HEIGHT: map_height  <= pwdata[grc_pkg::DIM_W-1:0];
        grc_pkg::REG_SCREEN_H:   view_height <= pwdata[grc_pkg::SH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      grc_pkg::REG_MAP_WIDTH:  prdata = grc_pkg::PDATA_W'(map_width);
      grc_pkg::REG_MAP_HEIGHT: prdata = grc_pkg::PDATA_W'(map_height);
      grc_pkg::REG_SCREEN_H:   prdata = grc_pkg::PDATA_W'(view_height);
      default:                 prdata = '0;
    endcase
  end

  // Tile map
  assign wr_in_range = (int'(req.tile_col) < MAX_COLS) && (int'(req.tile_row) < MAX_ROWS);
  assign wr_idx      = AW'(int'(req.tile_row) * MAX_COLS + int'(req.tile_col));
  assign ram_raddr   = AW'(int'(cy) * MAX_COLS + int'(cx));

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = accept && (req.cmd == grc_pkg::CMD_WRITE) && wr_in_range;
      ram_waddr = wr_idx;
      ram_wdata = req.tile_value;
    end
  end

  grc_ram #(
    .WIDTH (grc_pkg::COLOR_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  grc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Cast setup
  assign w_in  = (int'(map_width) > MAX_COLS) ? CW'(MAX_COLS) : CW'(map_width);
  assign h_in  = (int'(map_height) > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(map_height);
  assign cx_in = CW'(req.start_x >> grc_pkg::FRAC);
  assign cy_in = CW'(req.start_y >> grc_pkg::FRAC);
  assign adx_full = req.dir_x[grc_pkg::DIR_W-1] ? -req.dir_x : req.dir_x;
  assign ady_full = req.dir_y[grc_pkg::DIR_W-1] ? -req.dir_y : req.dir_y;

  // Walk datapath
  assign dx_pos = !dx[grc_pkg::DIR_W-1] && (dx != '0);
  assign dy_pos = !dy[grc_pkg::DIR_W-1] && (dy != '0);
  assign ddx    = (LW+1)'(nxl) - $signed({{(LW+1-grc_pkg::POS_W){1'b0}}, sx});
  assign ddy    = (LW+1)'(nyl) - $signed({{(LW+1-grc_pkg::POS_W){1'b0}}, sy});
  assign distx  = grc_pkg::MAG_W'(ddx[LW] ? -ddx : ddx);
  assign disty  = grc_pkg::MAG_W'(ddy[LW] ? -ddy : ddy);
  assign takex  = (dx != '0) && ((dy == '0) || (pdx <= pdy));
  assign cx_step = dx_pos ? cx + CW'(1) : cx - CW'(1);
  assign cy_step = dy_pos ? cy + CW'(1) : cy - CW'(1);

  assign off_s = $signed({1'b0, div_rsp.quo});
  assign sx_s  = $signed({{(grc_pkg::HP_W-grc_pkg::POS_W){1'b0}}, sx});
  assign sy_s  = $signed({{(grc_pkg::HP_W-grc_pkg::POS_W){1'b0}}, sy});
  assign diffx = grc_pkg::DIFF_W'(hx) - grc_pkg::DIFF_W'(sx_s);
  assign diffy = grc_pkg::DIFF_W'(hy) - grc_pkg::DIFF_W'(sy_s);

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = grc_pkg::NUM_W'(last_p);
    div_req.den   = grc_pkg::DEN_W'(last_a);
    if (state == S_OFF) begin
      div_req.start = !div_run;
    end else if (state == S_HT) begin
      div_req.start = !div_run && (dot > 0);
      div_req.num   = {view_height, {(grc_pkg::FRAC + grc_pkg::DIR_FRAC){1'b0}}};
      div_req.den   = dot[grc_pkg::DEN_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      div_run   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (req.cmd == grc_pkg::CMD_CAST && cx_in < w_in && cy_in < h_in) begin
              state <= S_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (ram_rdata != '0) begin
            state <= crossed ? S_OFF : S_MUL;
          end else if (dx == '0 && dy == '0) begin
            state <= S_DONE;
          end else if (takex) begin
            state <= (cx_step < 0 || cx_step >= $signed(w)) ? S_DONE : S_RD;
          end else begin
            state <= (cy_step < 0 || cy_step >= $signed(h)) ? S_DONE : S_RD;
          end
        end
        S_OFF: begin
          div_run <= !div_rsp.done;
          if (div_rsp.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_SUM;
        S_SUM: state <= S_HT;
        S_HT: begin
          if (dot <= 0) begin
            state <= S_DONE;
          end else begin
            div_run <= !div_rsp.done;
            if (div_rsp.done) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_hit <= 1'b0;
        res_ht  <= '0;
        sx  <= req.start_x;
        sy  <= req.start_y;
        dx  <= req.dir_x;
        dy  <= req.dir_y;
        fx  <= req.fwd_x;
        fy  <= req.fwd_y;
        adx <= grc_pkg::ADIR_W'(adx_full);
        ady <= grc_pkg::ADIR_W'(ady_full);
        w   <= w_in;
        h   <= h_in;
        cx  <= cx_in;
        cy  <= cy_in;
        nxl <= (!req.dir_x[grc_pkg::DIR_W-1] && req.dir_x != '0)
               ? LW'((int'(cx_in) + 1) * ONE) : LW'(int'(cx_in) * ONE);
        nyl <= (!req.dir_y[grc_pkg::DIR_W-1] && req.dir_y != '0)
               ? LW'((int'(cy_in) + 1) * ONE) : LW'(int'(cy_in) * ONE);
        crossed <= 1'b0;
      end
      S_RD: begin
        pdx <= distx * ady;
        pdy <= disty * adx;
      end
      S_CHK: begin
        if (ram_rdata != '0) begin
          color <= ram_rdata;
          hx    <= sx_s;
          hy    <= sy_s;
        end else if (takex) begin
          crossed   <= 1'b1;
          last_x    <= 1'b1;
          last_line <= nxl;
          last_p    <= pdx;
          last_a    <= adx;
          cx        <= cx_step;
          nxl       <= dx_pos ? nxl + LW'(ONE) : nxl - LW'(ONE);
        end else begin
          crossed   <= 1'b1;
          last_x    <= 1'b0;
          last_line <= nyl;
          last_p    <= pdy;
          last_a    <= ady;
          cy        <= cy_step;
          nyl       <= dy_pos ? nyl + LW'(ONE) : nyl - LW'(ONE);
        end
      end
      S_OFF: begin
        if (last_x) begin
          hx <= grc_pkg::HP_W'(last_line);
          hy <= dy_pos ? sy_s + off_s : sy_s - off_s;
        end else begin
          hy <= grc_pkg::HP_W'(last_line);
          hx <= dx_pos ? sx_s + off_s : sx_s - off_s;
        end
      end
      S_MUL: begin
        m1 <= diffx * fx;
        m2 <= diffy * fy;
      end
      S_SUM: begin
        res_hit <= 1'b1;
        dot     <= grc_pkg::DOT_W'(m1) + grc_pkg::DOT_W'(m2);
      end
      S_HT: begin
        if (dot <= 0) begin
          res_ht <= grc_pkg::HEIGHT_MAX;
        end else if (div_rsp.done) begin
          res_ht <= (div_rsp.ovf || div_rsp.quo > grc_pkg::QUO_W'(grc_pkg::HEIGHT_MAX))
                    ? grc_pkg::HEIGHT_MAX : div_rsp.quo[grc_pkg::HT_W-1:0];
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp.hit        <= res_hit;
          rsp.hit_x      <= res_hit ? hx[grc_pkg::POS_W-1:0] : '0;
          rsp.hit_y      <= res_hit ? hy[grc_pkg::POS_W-1:0] : '0;
          rsp.hit_color  <= res_hit ? color : '0;
          rsp.col_height <= res_hit ? res_ht : '0;
        end
      end
      default: ;
    endcase
  end

  assign rsp_data_zero = (rsp.hit_x == '0) && (rsp.hit_y == '0) && (rsp.col_height == '0);

  `ASSERT_CLK(a_hit_color, rsp_valid && rsp.hit |-> rsp.hit_color != '0, "hit without color")
  `ASSERT_CLK(a_miss_zero, rsp_valid && !rsp.hit |-> rsp_data_zero, "miss not zero")
  `ASSERT_NEVER(a_walk_nowr, ram_we && (state == S_RD || state == S_CHK), "map write during walk")
  `ASSERT_CLK(a_div_once, div_req.start |=> !div_req.start, "divider restarted")
endmodule
